@@ sv/rrtrl_pkg.sv @@
// ----------------------------------------------------------------------------
// rrtrl_pkg
// Shared types and constants of the round-robin task run list.
// ----------------------------------------------------------------------------
`default_nettype none

package rrtrl_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 5;
  localparam int unsigned PRI_W    = 8;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned CNT_O_W  = 6;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [PRI_W-1:0] INIT_SLICE_RST = 8'd2;

  // register index, taken from paddr[2]
  localparam logic REG_INIT_SLICE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NO_SLOT = 2'd1,
    STS_NOT_RUN = 2'd2,
    STS_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_ALLOC = 2'd1,
    SLOT_RUN   = 2'd2
  } slot_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_RUN_RD,
    S_RUN_WR,
    S_TICK,
    S_TICK_T,
    S_TICK_S,
    S_SLP_RD,
    S_SLP_CHK,
    S_SLP_WALK,
    S_SLP_FIX,
    S_SLP_CUR,
    S_SLP_FIN,
    S_OUT
  } rrtrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ALLOC_STEP,
    OP_ALLOC_TAKE,
    OP_ALLOC_NONE,
    OP_RUN,
    OP_TICK_ADV,
    OP_TICK_TASK,
    OP_TICK_FIN,
    OP_SLP_PREP,
    OP_WALK,
    OP_SLP_FIX,
    OP_SLP_FIN,
    OP_RES_ERR,
    OP_RES_EMPTY,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic id_ok;
    logic cnt_zero;
    logic stat_free;
    logic stat_run;
    logic rd_ok;
    logic scan_last;
    logic walk_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/rrtrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrtrl_ctrl
// Sequencer: steps each item through its read, scan and write phases.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtrl_ctrl import rrtrl_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [MODE_W-1:0] mode_i,
  output logic                   in_stall_o,
  input  wire dp_sts_t           sts_i,
  output dp_op_e                 op_o
);

  rrtrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD;
          case (mode_e'(mode_i))
            MODE_ALLOC: state_d = S_ALLOC;
            MODE_RUN:   state_d = S_RUN_RD;
            MODE_TICK:  state_d = S_TICK;
            MODE_SLEEP: state_d = S_SLP_RD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (sts_i.rd_ok && sts_i.stat_free) begin
          op_o    = OP_ALLOC_TAKE;
          state_d = S_OUT;
        end else if (sts_i.rd_ok && sts_i.scan_last) begin
          op_o    = OP_ALLOC_NONE;
          state_d = S_OUT;
        end else begin
          op_o = OP_ALLOC_STEP;
        end
      end
      S_RUN_RD: begin
        if (!sts_i.id_ok) begin
          op_o    = OP_RES_ERR;
          state_d = S_OUT;
        end else begin
          state_d = S_RUN_WR;
        end
      end
      S_RUN_WR: begin
        op_o    = OP_RUN;
        state_d = S_OUT;
      end
      S_TICK: begin
        if (sts_i.cnt_zero) begin
          op_o    = OP_RES_EMPTY;
          state_d = S_OUT;
        end else begin
          op_o    = OP_TICK_ADV;
          state_d = S_TICK_T;
        end
      end
      S_TICK_T: begin
        op_o    = OP_TICK_TASK;
        state_d = S_TICK_S;
      end
      S_TICK_S: begin
        op_o    = OP_TICK_FIN;
        state_d = S_OUT;
      end
      S_SLP_RD: begin
        if (!sts_i.id_ok) begin
          op_o    = OP_RES_ERR;
          state_d = S_OUT;
        end else begin
          op_o    = OP_SLP_PREP;
          state_d = S_SLP_CHK;
        end
      end
      S_SLP_CHK: begin
        if (!sts_i.stat_run || sts_i.cnt_zero) begin
          op_o    = OP_RES_ERR;
          state_d = S_OUT;
        end else begin
          state_d = S_SLP_WALK;
        end
      end
      S_SLP_WALK: begin
        op_o = OP_WALK;
        if (sts_i.rd_ok && sts_i.walk_last) begin
          state_d = S_SLP_FIX;
        end
      end
      S_SLP_FIX: begin
        op_o    = OP_SLP_FIX;
        state_d = S_SLP_CUR;
      end
      S_SLP_CUR: begin
        if (sts_i.cnt_zero) begin
          op_o    = OP_RES_EMPTY;
          state_d = S_OUT;
        end else begin
          state_d = S_SLP_FIN;
        end
      end
      S_SLP_FIN: begin
        op_o    = OP_SLP_FIN;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          op_o    = OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/rrtrl_dp.sv @@
// ----------------------------------------------------------------------------
// rrtrl_dp
// Datapath: slot state, slice and run list memories, indices and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtrl_dp import rrtrl_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_op_e             op_i,
  output dp_sts_t                 sts_o,
  input  wire logic [ID_W-1:0]    task_id_i,
  input  wire logic [PRI_W-1:0]   priority_req_i,
  input  wire logic               cfg_we_i,
  input  wire logic [PRI_W-1:0]   cfg_wdata_i,
  output logic [PRI_W-1:0]        init_slice_o,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic [STS_W-1:0]        status_o,
  output logic [ID_W-1:0]         result_task_o,
  output logic [PRI_W-1:0]        timer_reload_o,
  output logic                    do_switch_o,
  output logic [CNT_O_W-1:0]      running_count_o
);

  localparam int unsigned IW   = $clog2(TASK_SLOTS);
  localparam int unsigned CW   = $clog2(TASK_SLOTS + 1);
  localparam int unsigned CMPW = (ID_W > CW) ? ID_W : CW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C  = CW'(TASK_SLOTS);

  // storage
  logic [1:0]       stat_mem  [TASK_SLOTS];
  logic [PRI_W-1:0] slice_mem [TASK_SLOTS];
  logic [ID_W-1:0]  list_mem  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] stat_vld_q, slice_vld_q;
  logic             list_v0_q;

  logic [1:0]       stat_rd_q;
  logic             stat_rv_q, stat_r0_q;
  logic [PRI_W-1:0] slice_rd_q;
  logic             slice_rv_q, slice_r0_q;
  logic [ID_W-1:0]  list_rd_q;
  logic             list_rv_q;

  // item and walk registers
  logic [ID_W-1:0]  id_q;
  logic [PRI_W-1:0] pri_q;
  logic [PRI_W-1:0] init_slice_q;
  logic [IW-1:0]    cur_q, scan_q, ridx_q, pos_q;
  logic [CW-1:0]    cnt_q;
  logic             rv_q, found_q, wascur_q;
  logic [ID_W-1:0]  task_q;

  logic [STS_W-1:0] res_sts_q;
  logic [ID_W-1:0]  res_task_q;
  logic [PRI_W-1:0] res_reload_q;
  logic             res_sw_q;

  logic                out_valid_q;
  logic [STS_W-1:0]    out_sts_q;
  logic [ID_W-1:0]     out_task_q;
  logic [PRI_W-1:0]    out_reload_q;
  logic                out_sw_q;
  logic [CNT_O_W-1:0]  out_cnt_q;

  logic             id_ok;
  logic [IW-1:0]    id_idx, id_ra;
  logic [CW-1:0]    cur_inc, cnt_dec;
  logic [IW-1:0]    nxt_idx, cur_adj, cur_fix, walk_end;
  logic [1:0]       stat_cur;
  logic [PRI_W-1:0] slice_cur;
  logic [ID_W-1:0]  list_cur;
  logic             run_add, out_free;

  logic [IW-1:0]    stat_ra, slice_ra, list_ra;
  logic             stat_we, slice_we, list_we;
  logic [IW-1:0]    stat_wa, slice_wa, list_wa;
  logic [1:0]       stat_wd;
  logic [ID_W-1:0]  list_wd;

  assign id_ok    = CMPW'(id_q) < CMPW'(TASK_SLOTS);
  assign id_idx   = IW'(id_q);
  assign id_ra    = id_ok ? id_idx : '0;
  assign cur_inc  = CW'(cur_q) + CW'(1);
  assign nxt_idx  = (cur_inc >= cnt_q) ? '0 : IW'(cur_inc);
  assign cnt_dec  = cnt_q - CW'(1);
  assign walk_end = IW'(cnt_dec);
  assign cur_adj  = (pos_q < cur_q) ? (cur_q - IW'(1)) : cur_q;
  assign cur_fix  = (CW'(cur_adj) >= cnt_dec) ? '0 : cur_adj;

  // entries never written read as their reset value
  assign stat_cur  = stat_rv_q ? stat_rd_q : (stat_r0_q ? SLOT_RUN : SLOT_FREE);
  assign slice_cur = slice_rv_q ? slice_rd_q : (slice_r0_q ? init_slice_q : '0);
  assign list_cur  = list_rv_q ? list_rd_q : '0;

  assign run_add  = (stat_cur != SLOT_RUN) && (cnt_q < SLOTS_C);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_ra  = (op_i == OP_ALLOC_STEP) ? scan_q : id_ra;
    slice_ra = (op_i == OP_TICK_TASK) ? IW'(list_cur) : id_ra;
    case (op_i)
      OP_TICK_ADV: list_ra = nxt_idx;
      OP_WALK:     list_ra = scan_q;
      default:     list_ra = cur_q;
    endcase
  end

  always_comb begin
    stat_we  = 1'b0;
    stat_wa  = id_idx;
    stat_wd  = SLOT_ALLOC;
    slice_we = 1'b0;
    slice_wa = id_idx;
    list_we  = 1'b0;
    list_wa  = IW'(cnt_q);
    list_wd  = id_q;
    case (op_i)
      OP_ALLOC_TAKE: begin
        stat_we = 1'b1;
        stat_wa = ridx_q;
      end
      OP_RUN: begin
        slice_we = (pri_q != '0);
        stat_we  = run_add;
        stat_wd  = SLOT_RUN;
        list_we  = run_add;
      end
      OP_WALK: begin
        // entries behind the sleeper move down by one
        list_we = rv_q && found_q;
        list_wa = ridx_q - IW'(1);
        list_wd = list_cur;
      end
      OP_SLP_FIX: begin
        stat_we = 1'b1;
      end
      default: begin
        stat_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    if (slice_we) begin
      slice_mem[slice_wa] <= pri_q;
    end
    if (list_we) begin
      list_mem[list_wa] <= list_wd;
    end
    stat_rd_q  <= stat_mem[stat_ra];
    stat_rv_q  <= stat_vld_q[stat_ra];
    stat_r0_q  <= (stat_ra == '0);
    slice_rd_q <= slice_mem[slice_ra];
    slice_rv_q <= slice_vld_q[slice_ra];
    slice_r0_q <= (slice_ra == '0);
    list_rd_q  <= list_mem[list_ra];
    list_rv_q  <= list_v0_q || (list_ra != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_vld_q   <= '0;
      slice_vld_q  <= '0;
      list_v0_q    <= 1'b0;
      init_slice_q <= INIT_SLICE_RST;
    end else begin
      if (stat_we) begin
        stat_vld_q[stat_wa] <= 1'b1;
      end
      if (slice_we) begin
        slice_vld_q[slice_wa] <= 1'b1;
      end else if (cfg_we_i) begin
        slice_vld_q[0] <= 1'b0;
      end
      if (list_we && (list_wa == '0)) begin
        list_v0_q <= 1'b1;
      end
      if (cfg_we_i) begin
        init_slice_q <= cfg_wdata_i;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      cnt_q       <= CW'(1);
      scan_q      <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      wascur_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        OP_LOAD: begin
          scan_q   <= '0;
          rv_q     <= 1'b0;
          found_q  <= 1'b0;
          wascur_q <= 1'b0;
        end
        OP_ALLOC_STEP: begin
          rv_q <= 1'b1;
          if (scan_q != LAST_IDX) begin
            scan_q <= scan_q + IW'(1);
          end
        end
        OP_RUN: begin
          if (run_add) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        OP_TICK_ADV: begin
          cur_q <= nxt_idx;
        end
        OP_SLP_PREP: begin
          if (CW'(cur_q) >= cnt_q) begin
            cur_q <= '0;
          end
        end
        OP_WALK: begin
          rv_q <= 1'b1;
          if (scan_q != walk_end) begin
            scan_q <= scan_q + IW'(1);
          end
          if (rv_q && !found_q && (list_cur == id_q)) begin
            found_q <= 1'b1;
          end
          if (rv_q && (ridx_q == cur_q)) begin
            wascur_q <= (list_cur == id_q);
          end
        end
        OP_SLP_FIX: begin
          cnt_q <= cnt_dec;
          cur_q <= cur_fix;
        end
        default: begin
          rv_q <= rv_q;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        id_q  <= task_id_i;
        pri_q <= priority_req_i;
      end
      OP_ALLOC_STEP: begin
        ridx_q <= scan_q;
      end
      OP_ALLOC_TAKE: begin
        res_sts_q    <= STS_OK;
        res_task_q   <= ID_W'(ridx_q);
        res_reload_q <= '0;
        res_sw_q     <= 1'b0;
      end
      OP_ALLOC_NONE: begin
        res_sts_q    <= STS_NO_SLOT;
        res_task_q   <= '0;
        res_reload_q <= '0;
        res_sw_q     <= 1'b0;
      end
      OP_RUN: begin
        res_sts_q    <= STS_OK;
        res_task_q   <= id_q;
        res_reload_q <= '0;
        res_sw_q     <= 1'b0;
      end
      OP_TICK_TASK: begin
        task_q <= list_cur;
      end
      OP_TICK_FIN: begin
        res_sts_q    <= STS_OK;
        res_task_q   <= task_q;
        res_reload_q <= slice_cur;
        res_sw_q     <= (cnt_q >= CW'(2));
      end
      OP_WALK: begin
        ridx_q <= scan_q;
        if (rv_q && !found_q && (list_cur == id_q)) begin
          pos_q <= ridx_q;
        end
      end
      OP_SLP_FIN: begin
        res_sts_q    <= STS_OK;
        res_task_q   <= list_cur;
        res_reload_q <= '0;
        res_sw_q     <= wascur_q;
      end
      OP_RES_ERR: begin
        res_sts_q    <= STS_NOT_RUN;
        res_task_q   <= '0;
        res_reload_q <= '0;
        res_sw_q     <= 1'b0;
      end
      OP_RES_EMPTY: begin
        res_sts_q    <= STS_EMPTY;
        res_task_q   <= '0;
        res_reload_q <= '0;
        res_sw_q     <= 1'b0;
      end
      OP_EMIT: begin
        out_sts_q    <= res_sts_q;
        out_task_q   <= res_task_q;
        out_reload_q <= res_reload_q;
        out_sw_q     <= res_sw_q;
        out_cnt_q    <= CNT_O_W'(cnt_q);
      end
      default: begin
        task_q <= task_q;
      end
    endcase
  end

  always_comb begin
    sts_o.id_ok     = id_ok;
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.stat_free = (stat_cur == SLOT_FREE);
    sts_o.stat_run  = (stat_cur == SLOT_RUN);
    sts_o.rd_ok     = rv_q;
    sts_o.scan_last = (ridx_q == LAST_IDX);
    sts_o.walk_last = (ridx_q == walk_end);
    sts_o.out_free  = out_free;
  end

  assign init_slice_o    = init_slice_q;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_sts_q;
  assign result_task_o   = out_task_q;
  assign timer_reload_o  = out_reload_q;
  assign do_switch_o     = out_sw_q;
  assign running_count_o = out_cnt_q;

endmodule

`default_nettype wire

@@ sv/round_robin_task_run_list.sv @@
// One item at a time: the next is taken once the result sits in the output
// register; the slot scan and the run list walk set the worst-case latency.
// Reset: slot 0 running with initial_slice, all other slots free, one task
// in the list; per-entry valid flags give this at once, no clearing pass.
// ----------------------------------------------------------------------------
// round_robin_task_run_list
// Round-robin task scheduler: slot allocation, run list, tick and sleep.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_run_list import rrtrl_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [APB_AW-1:0]   paddr,
  input  wire logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [ID_W-1:0]     task_id_i,
  input  wire logic [PRI_W-1:0]    priority_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STS_W-1:0]         status_o,
  output logic [ID_W-1:0]          result_task_o,
  output logic [PRI_W-1:0]         timer_reload_o,
  output logic                     do_switch_o,
  output logic [CNT_O_W-1:0]       running_count_o
);

  dp_op_e           op;
  dp_sts_t          sts;
  logic             cfg_we;
  logic             reg_hit;
  logic [PRI_W-1:0] init_slice;

  assign reg_hit = (paddr[APB_AW-1] == REG_INIT_SLICE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(init_slice) : '0;

  rrtrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  rrtrl_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .sts_o           (sts),
    .task_id_i       (task_id_i),
    .priority_req_i  (priority_req_i),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (pwdata[PRI_W-1:0]),
    .init_slice_o    (init_slice),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .result_task_o   (result_task_o),
    .timer_reload_o  (timer_reload_o),
    .do_switch_o     (do_switch_o),
    .running_count_o (running_count_o)
  );

endmodule

`default_nettype wire

@@ sv/rrtrl_checker.sv @@
// ----------------------------------------------------------------------------
// rrtrl_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrtrl_checker import rrtrl_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [STS_W-1:0]   status_o,
  input wire logic [ID_W-1:0]    result_task_o,
  input wire logic [PRI_W-1:0]   timer_reload_o,
  input wire logic               do_switch_o,
  input wire logic [CNT_O_W-1:0] running_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(result_task_o) && $stable(timer_reload_o) &&
      $stable(do_switch_o) && $stable(running_count_o))
    else $error("result item changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STS_EMPTY) |->
      (result_task_o == '0) && (timer_reload_o == '0) && !do_switch_o)
    else $error("empty list result carries data");

  a_switch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && do_switch_o |-> (status_o == STS_OK))
    else $error("switch flagged on a failed item");

  a_busy_before_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item without an item in progress");

endmodule

bind round_robin_task_run_list rrtrl_checker u_rrtrl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .result_task_o   (result_task_o),
  .timer_reload_o  (timer_reload_o),
  .do_switch_o     (do_switch_o),
  .running_count_o (running_count_o)
);

`default_nettype wire
